@@ sv/lifexp_pkg.sv @@
package lifexp_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS         = 16;
   localparam int INDEX_WIDTH       = 16;
   localparam int Q_WIDTH           = 32;
   localparam int REFR_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH   = 4;
   localparam int WIDE_WIDTH        = 64;

   localparam logic signed [Q_WIDTH-1:0] Q_MAX =
      {1'b0, {(Q_WIDTH-1){1'b1}}};
   localparam logic signed [Q_WIDTH-1:0] Q_MIN =
      {1'b1, {(Q_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE_WIDTH-1:0] WIDE_Q_MAX = WIDE_WIDTH'(Q_MAX);
   localparam logic signed [WIDE_WIDTH-1:0] WIDE_Q_MIN = WIDE_WIDTH'(Q_MIN);
   localparam logic signed [WIDE_WIDTH-1:0] Q_ROUND =
      WIDE_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [Q_WIDTH-1:0] Q_ONE =
      Q_WIDTH'(64'sd1 <<< FRAC_BITS);

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_EXT_CURRENT   = 4'd0,
      REG_P20_GAIN      = 4'd1,
      REG_P11_EXC_DECAY = 4'd2,
      REG_P11_INH_DECAY = 4'd3,
      REG_P21_EXC_GAIN  = 4'd4,
      REG_P21_INH_GAIN  = 4'd5,
      REG_P22_DECAY     = 4'd6,
      REG_THRESHOLD     = 4'd7
   } lifexp_reg_type;

   typedef struct packed {
      logic signed [Q_WIDTH-1:0] ext_current;
      logic signed [Q_WIDTH-1:0] p20_gain;
      logic signed [Q_WIDTH-1:0] p11_exc_decay;
      logic signed [Q_WIDTH-1:0] p11_inh_decay;
      logic signed [Q_WIDTH-1:0] p21_exc_gain;
      logic signed [Q_WIDTH-1:0] p21_inh_gain;
      logic signed [Q_WIDTH-1:0] p22_decay;
      logic signed [Q_WIDTH-1:0] threshold;
   } lifexp_cfg_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]    neuron_index;
      logic                      last_neuron;
      logic signed [Q_WIDTH-1:0] stim_0;
      logic signed [Q_WIDTH-1:0] stim_1;
      logic signed [Q_WIDTH-1:0] weighted_exc;
      logic signed [Q_WIDTH-1:0] weighted_inh;
      logic signed [Q_WIDTH-1:0] syn_exc;
      logic signed [Q_WIDTH-1:0] syn_inh;
      logic [REFR_WIDTH-1:0]     refractory_left;
      logic signed [Q_WIDTH-1:0] membrane_v;
   } lifexp_item_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]    neuron_index_out;
      logic                      last_out;
      logic signed [Q_WIDTH-1:0] syn_exc_out;
      logic signed [Q_WIDTH-1:0] syn_inh_out;
      logic [REFR_WIDTH-1:0]     refractory_out;
      logic signed [Q_WIDTH-1:0] membrane_v_out;
      logic signed [Q_WIDTH-1:0] stim_0_out;
      logic signed [Q_WIDTH-1:0] stim_1_out;
      logic                      fired;
   } lifexp_result_type;

   // Clamp a wide signed value into the Q range
   function automatic logic signed [Q_WIDTH-1:0] q_sat(
      input logic signed [WIDE_WIDTH-1:0] v
   );
      logic signed [Q_WIDTH-1:0] r;
      if (v > WIDE_Q_MAX) begin
         r = Q_MAX;
      end else if (v < WIDE_Q_MIN) begin
         r = Q_MIN;
      end else begin
         r = v[Q_WIDTH-1:0];
      end
      return r;
   endfunction

   // Saturating add
   function automatic logic signed [Q_WIDTH-1:0] q_add(
      input logic signed [Q_WIDTH-1:0] a,
      input logic signed [Q_WIDTH-1:0] b
   );
      logic signed [WIDE_WIDTH-1:0] s;
      s = WIDE_WIDTH'(a) + WIDE_WIDTH'(b);
      return q_sat(s);
   endfunction

   // Saturating subtract
   function automatic logic signed [Q_WIDTH-1:0] q_sub(
      input logic signed [Q_WIDTH-1:0] a,
      input logic signed [Q_WIDTH-1:0] b
   );
      logic signed [WIDE_WIDTH-1:0] s;
      s = WIDE_WIDTH'(a) - WIDE_WIDTH'(b);
      return q_sat(s);
   endfunction

   // Fixed-point multiply, round half up, saturate
   function automatic logic signed [Q_WIDTH-1:0] q_mul(
      input logic signed [Q_WIDTH-1:0] a,
      input logic signed [Q_WIDTH-1:0] b
   );
      logic signed [WIDE_WIDTH-1:0] p;
      p = WIDE_WIDTH'(a) * WIDE_WIDTH'(b);
      p = p + Q_ROUND;
      return q_sat(p >>> FRAC_BITS);
   endfunction

endpackage

@@ sv/lif_exp_synapse_neuron_step_core.sv @@
// LIF neuron step with exponential synaptic currents, Q16.16 fixed point.
// Request channel (req_*): one neuron's full state for one time step.
// Response channel (rsp_*): the updated state, one response per request,
// in request order, with a fired flag when the new voltage is above the
// threshold register.
// CSR channel (csr_*): writes one of eight coefficient registers by index;
// csr_ready is always high and unknown indexes are ignored. Write the
// registers only while no request is in flight.
// Each request is held in the input register, then passes through the
// update logic into the response register, which drives rsp_valid.
// Throughput: one neuron per cycle while rsp_ready is high; the four
// propagator multipliers work in parallel in the single update stage.
// Stall: when rsp_ready is low the response register holds, the input
// register fills behind it, and req_ready drops only once both are full.
// Reset: synchronous; clears both stages and loads the coefficient
// defaults (voltage decay 1.0, everything else 0).
module lif_exp_synapse_neuron_step_core
   import lifexp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [Q_WIDTH-1:0]         csr_wdata,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [INDEX_WIDTH-1:0]     req_neuron_index,
   input  logic                       req_last_neuron,
   input  logic signed [Q_WIDTH-1:0]  req_stim_0,
   input  logic signed [Q_WIDTH-1:0]  req_stim_1,
   input  logic signed [Q_WIDTH-1:0]  req_weighted_exc,
   input  logic signed [Q_WIDTH-1:0]  req_weighted_inh,
   input  logic signed [Q_WIDTH-1:0]  req_syn_exc,
   input  logic signed [Q_WIDTH-1:0]  req_syn_inh,
   input  logic [REFR_WIDTH-1:0]      req_refractory_left,
   input  logic signed [Q_WIDTH-1:0]  req_membrane_v,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_WIDTH-1:0]     rsp_neuron_index_out,
   output logic                       rsp_last_out,
   output logic signed [Q_WIDTH-1:0]  rsp_syn_exc_out,
   output logic signed [Q_WIDTH-1:0]  rsp_syn_inh_out,
   output logic [REFR_WIDTH-1:0]      rsp_refractory_out,
   output logic signed [Q_WIDTH-1:0]  rsp_membrane_v_out,
   output logic signed [Q_WIDTH-1:0]  rsp_stim_0_out,
   output logic signed [Q_WIDTH-1:0]  rsp_stim_1_out,
   output logic                       rsp_fired
);

   lifexp_cfg_type    cfg;
   lifexp_item_type   req_item;
   lifexp_result_type upd_result;

   logic              in_valid_ff;
   logic              in_valid_in;
   lifexp_item_type   in_item_ff;
   lifexp_item_type   in_item_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   lifexp_result_type out_res_ff;
   lifexp_result_type out_res_in;
   logic              advance;
   logic              req_xfer;

   assign csr_ready = 1'b1;

   lifexp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Gather the request fields
   always_comb begin
      req_item.neuron_index    = req_neuron_index;
      req_item.last_neuron     = req_last_neuron;
      req_item.stim_0          = req_stim_0;
      req_item.stim_1          = req_stim_1;
      req_item.weighted_exc    = req_weighted_exc;
      req_item.weighted_inh    = req_weighted_inh;
      req_item.syn_exc         = req_syn_exc;
      req_item.syn_inh         = req_syn_inh;
      req_item.refractory_left = req_refractory_left;
      req_item.membrane_v      = req_membrane_v;
   end

   lifexp_update u_update (
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (upd_result)
   );

   // Advance the input stage when the response register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = upd_result;
         in_valid_in  = 1'b0;
      end
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_neuron_index_out = out_res_ff.neuron_index_out;
   assign rsp_last_out         = out_res_ff.last_out;
   assign rsp_syn_exc_out      = out_res_ff.syn_exc_out;
   assign rsp_syn_inh_out      = out_res_ff.syn_inh_out;
   assign rsp_refractory_out   = out_res_ff.refractory_out;
   assign rsp_membrane_v_out   = out_res_ff.membrane_v_out;
   assign rsp_stim_0_out       = out_res_ff.stim_0_out;
   assign rsp_stim_1_out       = out_res_ff.stim_1_out;
   assign rsp_fired            = out_res_ff.fired;

   // A stalled input stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input stage lost or changed a stalled item");

   // Requests are refused only when both stages are full and blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("req_ready low without a full pipeline");

   // Every advance lands a response in the output register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach the response register");

   // A refractory neuron keeps its voltage
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.refractory_left != '0)
         |=> (out_res_ff.membrane_v_out == $past(in_item_ff.membrane_v)))
      else $error("refractory neuron voltage changed");

endmodule

@@ sv/lifexp_csr.sv @@
module lifexp_csr
   import lifexp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [Q_WIDTH-1:0]         csr_wdata,
   output lifexp_cfg_type             cfg
);

   lifexp_cfg_type cfg_ff;
   lifexp_cfg_type cfg_in;

   // Decode the register index; drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_EXT_CURRENT:   cfg_in.ext_current   = csr_wdata;
            REG_P20_GAIN:      cfg_in.p20_gain      = csr_wdata;
            REG_P11_EXC_DECAY: cfg_in.p11_exc_decay = csr_wdata;
            REG_P11_INH_DECAY: cfg_in.p11_inh_decay = csr_wdata;
            REG_P21_EXC_GAIN:  cfg_in.p21_exc_gain  = csr_wdata;
            REG_P21_INH_GAIN:  cfg_in.p21_inh_gain  = csr_wdata;
            REG_P22_DECAY:     cfg_in.p22_decay     = csr_wdata;
            REG_THRESHOLD:     cfg_in.threshold     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Reset: voltage decay 1.0, every other register 0
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {{6{{Q_WIDTH{1'b0}}}}, Q_ONE, {Q_WIDTH{1'b0}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/lifexp_update.sv @@
module lifexp_update
   import lifexp_pkg::*;
(
   input  lifexp_cfg_type    cfg,
   input  lifexp_item_type   item,
   output lifexp_result_type result
);

   logic signed [Q_WIDTH-1:0]    se;
   logic signed [Q_WIDTH-1:0]    si;
   logic signed [Q_WIDTH-1:0]    drive;
   logic signed [Q_WIDTH-1:0]    t_leak;
   logic signed [Q_WIDTH-1:0]    t_exc;
   logic signed [Q_WIDTH-1:0]    t_inh;
   logic signed [Q_WIDTH-1:0]    t_drive;
   logic signed [WIDE_WIDTH-1:0] v_acc;
   logic signed [Q_WIDTH-1:0]    v_next;
   logic signed [Q_WIDTH-1:0]    exc_rel;
   logic                         active;

   // Add this step's spike input to the synaptic currents
   assign se     = q_add(item.syn_exc, item.weighted_exc);
   assign si     = q_add(item.syn_inh, item.weighted_inh);
   assign active = (item.refractory_left == '0);

   // Propagator terms, all four multipliers side by side
   assign drive   = q_add(cfg.ext_current, item.stim_0);
   assign t_leak  = q_mul(item.membrane_v, cfg.p22_decay);
   assign t_exc   = q_mul(se, cfg.p21_exc_gain);
   assign t_inh   = q_mul(si, cfg.p21_inh_gain);
   assign t_drive = q_mul(drive, cfg.p20_gain);

   // Sum exactly, saturate once; hold voltage while refractory
   assign v_acc  = WIDE_WIDTH'(t_leak) + WIDE_WIDTH'(t_exc)
                 + WIDE_WIDTH'(t_inh) + WIDE_WIDTH'(t_drive);
   assign v_next = active ? q_sat(v_acc) : item.membrane_v;

   // Excitatory current relaxes toward stim_1
   assign exc_rel = q_sub(se, item.stim_1);

   always_comb begin
      result.neuron_index_out = item.neuron_index;
      result.last_out         = item.last_neuron;
      result.syn_exc_out      = q_add(q_mul(exc_rel, cfg.p11_exc_decay), item.stim_1);
      result.syn_inh_out      = q_mul(si, cfg.p11_inh_decay);
      result.refractory_out   = active ? '0 : item.refractory_left - REFR_WIDTH'(1);
      result.membrane_v_out   = v_next;
      result.stim_0_out       = item.stim_0;
      result.stim_1_out       = item.stim_1;
      result.fired            = (v_next > cfg.threshold);
   end

endmodule

@@ tb/sv/tb_lif_exp_synapse_neuron_step_core.sv @@
module tb_lif_exp_synapse_neuron_step_core;
   import lifexp_pkg::*;

   typedef enum int {
      COEF_TYPICAL,
      COEF_RANDOM,
      COEF_ALL_MAX,
      COEF_ALL_MIN
   } coef_kind_type;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int REPORT_LIMIT    = 10;
   localparam int SETTLE_CYCLES   = 6;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [Q_WIDTH-1:0]        csr_wdata = '0;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [INDEX_WIDTH-1:0]    req_neuron_index = '0;
   logic                      req_last_neuron = 1'b0;
   logic signed [Q_WIDTH-1:0] req_stim_0 = '0;
   logic signed [Q_WIDTH-1:0] req_stim_1 = '0;
   logic signed [Q_WIDTH-1:0] req_weighted_exc = '0;
   logic signed [Q_WIDTH-1:0] req_weighted_inh = '0;
   logic signed [Q_WIDTH-1:0] req_syn_exc = '0;
   logic signed [Q_WIDTH-1:0] req_syn_inh = '0;
   logic [REFR_WIDTH-1:0]     req_refractory_left = '0;
   logic signed [Q_WIDTH-1:0] req_membrane_v = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [INDEX_WIDTH-1:0]    rsp_neuron_index_out;
   logic                      rsp_last_out;
   logic signed [Q_WIDTH-1:0] rsp_syn_exc_out;
   logic signed [Q_WIDTH-1:0] rsp_syn_inh_out;
   logic [REFR_WIDTH-1:0]     rsp_refractory_out;
   logic signed [Q_WIDTH-1:0] rsp_membrane_v_out;
   logic signed [Q_WIDTH-1:0] rsp_stim_0_out;
   logic signed [Q_WIDTH-1:0] rsp_stim_1_out;
   logic                      rsp_fired;

   // Neuron states waiting to be sent, and updates still owed by the block
   lifexp_item_type   neuron_queue[$];
   lifexp_result_type expected_updates[$];
   lifexp_cfg_type    coef_now;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  req_xfer = 1'b0;
   int  mismatches = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   int  n_refractory = 0;
   int  n_fired = 0;
   int  n_csr_writes = 0;

   lif_exp_synapse_neuron_step_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_neuron_index     (req_neuron_index),
      .req_last_neuron      (req_last_neuron),
      .req_stim_0           (req_stim_0),
      .req_stim_1           (req_stim_1),
      .req_weighted_exc     (req_weighted_exc),
      .req_weighted_inh     (req_weighted_inh),
      .req_syn_exc          (req_syn_exc),
      .req_syn_inh          (req_syn_inh),
      .req_refractory_left  (req_refractory_left),
      .req_membrane_v       (req_membrane_v),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_neuron_index_out (rsp_neuron_index_out),
      .rsp_last_out         (rsp_last_out),
      .rsp_syn_exc_out      (rsp_syn_exc_out),
      .rsp_syn_inh_out      (rsp_syn_inh_out),
      .rsp_refractory_out   (rsp_refractory_out),
      .rsp_membrane_v_out   (rsp_membrane_v_out),
      .rsp_stim_0_out       (rsp_stim_0_out),
      .rsp_stim_1_out       (rsp_stim_1_out),
      .rsp_fired            (rsp_fired)
   );

   always #5 clock = ~clock;

   // Clamp a 64-bit intermediate into the signed Q16.16 range
   function automatic logic signed [Q_WIDTH-1:0] clamp_q(input longint wide);
      if (wide > longint'(Q_MAX)) begin
         return Q_MAX;
      end
      if (wide < longint'(Q_MIN)) begin
         return Q_MIN;
      end
      return wide[Q_WIDTH-1:0];
   endfunction

   function automatic logic signed [Q_WIDTH-1:0] sat_add(
      input logic signed [Q_WIDTH-1:0] a,
      input logic signed [Q_WIDTH-1:0] b
   );
      return clamp_q(longint'(a) + longint'(b));
   endfunction

   // Full product, add half an LSB, arithmetic shift, then clamp
   function automatic logic signed [Q_WIDTH-1:0] fx_mul(
      input logic signed [Q_WIDTH-1:0] a,
      input logic signed [Q_WIDTH-1:0] b
   );
      longint prod;
      prod = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS - 1));
      return clamp_q(prod >>> FRAC_BITS);
   endfunction

   // One time step of one neuron under the given coefficients
   function automatic lifexp_result_type step_neuron(
      input lifexp_item_type it,
      input lifexp_cfg_type  cf
   );
      lifexp_result_type         r;
      logic signed [Q_WIDTH-1:0] exc_in;
      logic signed [Q_WIDTH-1:0] inh_in;
      logic signed [Q_WIDTH-1:0] stim1;
      logic signed [Q_WIDTH-1:0] v_new;
      longint                    acc;
      exc_in = sat_add(it.syn_exc, it.weighted_exc);
      inh_in = sat_add(it.syn_inh, it.weighted_inh);
      stim1  = it.stim_1;
      if (it.refractory_left == '0) begin
         acc = longint'(fx_mul(it.membrane_v, cf.p22_decay))
             + longint'(fx_mul(exc_in, cf.p21_exc_gain))
             + longint'(fx_mul(inh_in, cf.p21_inh_gain))
             + longint'(fx_mul(sat_add(cf.ext_current, it.stim_0), cf.p20_gain));
         v_new = clamp_q(acc);
         r.refractory_out = '0;
      end else begin
         v_new = it.membrane_v;
         r.refractory_out = it.refractory_left - 1'b1;
      end
      r.neuron_index_out = it.neuron_index;
      r.last_out         = it.last_neuron;
      r.syn_exc_out      = sat_add(fx_mul(clamp_q(longint'(exc_in) - longint'(stim1)),
                                          cf.p11_exc_decay), stim1);
      r.syn_inh_out      = fx_mul(inh_in, cf.p11_inh_decay);
      r.membrane_v_out   = v_new;
      r.stim_0_out       = it.stim_0;
      r.stim_1_out       = it.stim_1;
      r.fired            = $signed(v_new) > $signed(cf.threshold);
      return r;
   endfunction

   // Uniform value in plus or minus the given number of whole units
   function automatic logic signed [Q_WIDTH-1:0] near_zero(input int units);
      return $urandom_range(2 * (units << FRAC_BITS)) - (units << FRAC_BITS);
   endfunction

   // Mostly moderate values, with rails, zero and raw bit patterns mixed in
   function automatic logic signed [Q_WIDTH-1:0] rand_q();
      case ($urandom_range(9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return near_zero(20);
      endcase
   endfunction

   function automatic lifexp_item_type rand_neuron();
      lifexp_item_type it;
      it.neuron_index = INDEX_WIDTH'($urandom);
      it.last_neuron  = ($urandom_range(7) == 0);
      it.stim_0       = rand_q();
      it.stim_1       = rand_q();
      it.weighted_exc = rand_q();
      it.weighted_inh = rand_q();
      it.syn_exc      = rand_q();
      it.syn_inh      = rand_q();
      it.membrane_v   = rand_q();
      case ($urandom_range(9))
         0: it.refractory_left = 1;
         1: it.refractory_left = '1;
         2: it.refractory_left = REFR_WIDTH'($urandom);
         3, 4: it.refractory_left = REFR_WIDTH'($urandom_range(20, 2));
         default: it.refractory_left = '0;
      endcase
      return it;
   endfunction

   function automatic lifexp_item_type neuron_state(
      input logic [INDEX_WIDTH-1:0]    idx,
      input logic                      last,
      input logic signed [Q_WIDTH-1:0] s0,
      input logic signed [Q_WIDTH-1:0] s1,
      input logic signed [Q_WIDTH-1:0] we,
      input logic signed [Q_WIDTH-1:0] wi,
      input logic signed [Q_WIDTH-1:0] se,
      input logic signed [Q_WIDTH-1:0] si,
      input logic [REFR_WIDTH-1:0]     refr,
      input logic signed [Q_WIDTH-1:0] v
   );
      lifexp_item_type it;
      it = '{idx, last, s0, s1, we, wi, se, si, refr, v};
      return it;
   endfunction

   function automatic lifexp_cfg_type make_coefs(input coef_kind_type kind);
      lifexp_cfg_type c;
      case (kind)
         COEF_TYPICAL: begin
            c.ext_current   = near_zero(5);
            c.p20_gain      = $urandom_range(Q_ONE / 2);
            c.p11_exc_decay = $urandom_range(Q_ONE, Q_ONE - Q_ONE / 4);
            c.p11_inh_decay = $urandom_range(Q_ONE, Q_ONE - Q_ONE / 4);
            c.p21_exc_gain  = near_zero(1);
            c.p21_inh_gain  = near_zero(1);
            c.p22_decay     = $urandom_range(Q_ONE, Q_ONE - Q_ONE / 4);
            c.threshold     = near_zero(10);
         end
         COEF_ALL_MAX: c = {8{Q_MAX}};
         COEF_ALL_MIN: c = {8{Q_MIN}};
         default: c = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
      endcase
      return c;
   endfunction

   task automatic write_coef(
      input logic [CSR_INDEX_WIDTH-1:0] idx,
      input logic [Q_WIDTH-1:0]         val
   );
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write every coefficient, plus one index past the map that must be ignored
   task automatic load_coefs(input lifexp_cfg_type c);
      write_coef(REG_EXT_CURRENT, c.ext_current);
      write_coef(REG_P20_GAIN, c.p20_gain);
      write_coef(REG_P11_EXC_DECAY, c.p11_exc_decay);
      write_coef(REG_P11_INH_DECAY, c.p11_inh_decay);
      write_coef(REG_P21_EXC_GAIN, c.p21_exc_gain);
      write_coef(REG_P21_INH_GAIN, c.p21_inh_gain);
      write_coef(REG_THRESHOLD + CSR_INDEX_WIDTH'($urandom_range(8, 1)), $urandom);
      write_coef(REG_P22_DECAY, c.p22_decay);
      write_coef(REG_THRESHOLD, c.threshold);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued neuron is sent and every owed update is back, then let the pipe settle
   task automatic drain();
      @(posedge clock);
      while (neuron_queue.size() != 0 || req_valid || expected_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_pacing(input int mode);
      int send_idle_by_mode[4] = '{0, 85, 0, 22};
      int recv_stall_by_mode[4] = '{0, 0, 85, 22};
      send_idle_pct  = send_idle_by_mode[mode];
      recv_stall_pct = recv_stall_by_mode[mode];
   endtask

   task automatic note_field(
      input string         name,
      input logic [63:0]   got,
      input logic [63:0]   want,
      inout bit            bad
   );
      if (got !== want) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("update %0d, %s: expected %h, got %h", n_checked, name, want, got);
         end
         bad = 1'b1;
      end
   endtask

   // Driver: present the next neuron once the current one has transferred
   always @(negedge clock) begin : feed
      lifexp_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (neuron_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = neuron_queue.pop_front();
            req_valid           <= 1'b1;
            req_neuron_index    <= it.neuron_index;
            req_last_neuron     <= it.last_neuron;
            req_stim_0          <= it.stim_0;
            req_stim_1          <= it.stim_1;
            req_weighted_exc    <= it.weighted_exc;
            req_weighted_inh    <= it.weighted_inh;
            req_syn_exc         <= it.syn_exc;
            req_syn_inh         <= it.syn_inh;
            req_refractory_left <= it.refractory_left;
            req_membrane_v      <= it.membrane_v;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: track coefficient writes, predict on request transfer,
   // check on response transfer
   always @(posedge clock) begin : watch
      lifexp_item_type   it;
      lifexp_result_type got;
      lifexp_result_type want;
      bit                bad;
      if (reset) begin
         req_xfer <= 1'b0;
         coef_now = '0;
         coef_now.p22_decay = Q_ONE;
         expected_updates.delete();
      end else begin
         req_xfer <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            n_csr_writes++;
            case (csr_index)
               REG_EXT_CURRENT:   coef_now.ext_current   = csr_wdata;
               REG_P20_GAIN:      coef_now.p20_gain      = csr_wdata;
               REG_P11_EXC_DECAY: coef_now.p11_exc_decay = csr_wdata;
               REG_P11_INH_DECAY: coef_now.p11_inh_decay = csr_wdata;
               REG_P21_EXC_GAIN:  coef_now.p21_exc_gain  = csr_wdata;
               REG_P21_INH_GAIN:  coef_now.p21_inh_gain  = csr_wdata;
               REG_P22_DECAY:     coef_now.p22_decay     = csr_wdata;
               REG_THRESHOLD:     coef_now.threshold     = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            it = '{req_neuron_index, req_last_neuron, req_stim_0, req_stim_1,
                   req_weighted_exc, req_weighted_inh, req_syn_exc, req_syn_inh,
                   req_refractory_left, req_membrane_v};
            want = step_neuron(it, coef_now);
            expected_updates.push_back(want);
            n_sent++;
            if (it.refractory_left != '0) n_refractory++;
            if (want.fired) n_fired++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("unexpected response for neuron %0d", rsp_neuron_index_out);
               end
               mismatches++;
            end else begin
               want = expected_updates.pop_front();
               got = '{rsp_neuron_index_out, rsp_last_out, rsp_syn_exc_out,
                       rsp_syn_inh_out, rsp_refractory_out, rsp_membrane_v_out,
                       rsp_stim_0_out, rsp_stim_1_out, rsp_fired};
               bad = 1'b0;
               note_field("neuron_index_out", got.neuron_index_out,
                          want.neuron_index_out, bad);
               note_field("last_out", got.last_out, want.last_out, bad);
               note_field("syn_exc_out", got.syn_exc_out, want.syn_exc_out, bad);
               note_field("syn_inh_out", got.syn_inh_out, want.syn_inh_out, bad);
               note_field("refractory_out", got.refractory_out, want.refractory_out, bad);
               note_field("membrane_v_out", got.membrane_v_out, want.membrane_v_out, bad);
               note_field("stim_0_out", got.stim_0_out, want.stim_0_out, bad);
               note_field("stim_1_out", got.stim_1_out, want.stim_1_out, bad);
               note_field("fired", got.fired, want.fired, bad);
               if (bad) mismatches++;
               n_checked++;
            end
         end
      end
   end

   // Stimulus sequence: reset defaults, directed corners, then paced random phases
   initial begin : stimulus
      lifexp_item_type corners[$];
      coef_kind_type   phase_kind[PHASES] = '{COEF_TYPICAL, COEF_RANDOM, COEF_ALL_MAX,
                                              COEF_TYPICAL, COEF_ALL_MIN, COEF_RANDOM,
                                              COEF_TYPICAL, COEF_RANDOM};
      corners.push_back(neuron_state(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      corners.push_back(neuron_state('1, 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     0, Q_MAX));
      corners.push_back(neuron_state(1, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     0, Q_MIN));
      // excitatory sum and difference both hit the rails
      corners.push_back(neuron_state(2, 0, 0, Q_MIN, Q_MAX, 0, Q_MAX, 0, 0, 0));
      corners.push_back(neuron_state(3, 0, 0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0));
      // refractory neurons keep their voltage and may still report a spike
      corners.push_back(neuron_state(4, 0, 0, 0, 0, 0, 0, 0, 1, Q_MAX));
      corners.push_back(neuron_state(5, 1, 0, 0, 0, 0, 0, 0, '1, Q_MIN));
      corners.push_back(neuron_state(6, 0, Q_ONE, 2 * Q_ONE, Q_ONE, -Q_ONE, 3 * Q_ONE,
                                     -Q_ONE, 0, 5 * Q_ONE));
      corners.push_back(neuron_state(16'hAAAA, 0, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                     32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555));
      corners.push_back(neuron_state(16'h5555, 1, 32'hAAAA_AAAA, 32'h5555_5555,
                                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 16'h5555, 32'hAAAA_AAAA));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients first
      set_pacing(0);
      for (int i = 0; i < 4; i++) neuron_queue.push_back(corners[i]);
      drain();

      // corners under a plausible setting, then with every coefficient at the top rail
      load_coefs(make_coefs(COEF_TYPICAL));
      foreach (corners[i]) neuron_queue.push_back(corners[i]);
      drain();
      load_coefs(make_coefs(COEF_ALL_MAX));
      foreach (corners[i]) neuron_queue.push_back(corners[i]);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         load_coefs(make_coefs(phase_kind[ph]));
         set_pacing(ph % 4);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) neuron_queue.push_back(rand_neuron());
         drain();
      end

      $display("Checked %0d of %0d neuron updates (%0d refractory, %0d spiking)",
               n_checked, n_sent, n_refractory, n_fired);
      $display("across %0d register writes and four sender/receiver pacing modes",
               n_csr_writes);
      if (mismatches == 0 && expected_updates.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("Timed out with %0d updates outstanding", expected_updates.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
